// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/rtcdt_pkg.sv =====
// ----------------------------------------------------------------------------
// rtcdt_pkg
// Types, limits and helper functions for the RTC date/time check block.
// ----------------------------------------------------------------------------
package rtcdt_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [11:0] YEAR_MIN   = 12'd2013;
    localparam logic [11:0] YEAR_MAX   = 12'd2099;
    localparam logic [11:0] YEAR_BASE  = 12'd2000;
    localparam logic [5:0]  OFFSET_MAX = 6'd60;
    localparam logic [6:0]  SEC_WRAP   = 7'd60;
    localparam logic [5:0]  SEC_LAST   = 6'd59;
    localparam logic [5:0]  MIN_LAST   = 6'd59;
    localparam logic [4:0]  HOUR_LAST  = 5'd23;
    localparam logic [3:0]  MONTH_LAST = 4'd12;
    localparam logic [6:0]  YY_LAST    = 7'd99;

    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_NOV = 4'd11;

    typedef struct packed {
        logic       ok;
        logic [6:0] yy;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [5:0] offs;
        logic [4:0] mlen;
    } rtcdt_entry_t;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
            MON_FEB: len = leap ? 5'd29 : 5'd28;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // tens digit by reciprocal multiply, exact below 100
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [13:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = 14'(v) * 14'd103;
        tens = prod[13:10];
        ones = v - 7'(tens) * 7'd10;
        return {tens, ones[3:0]};
    endfunction

endpackage

// ===== design/rtcdt_item_if.sv =====
// ----------------------------------------------------------------------------
// rtcdt_item_if
// Input channel: date, time and seconds offset with valid/ready.
// ----------------------------------------------------------------------------
interface rtcdt_item_if;
    logic        valid;
    logic        ready;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [5:0]  offset_seconds;

    modport source (
        output valid, year, month, day, hour, minute, second, offset_seconds,
        input  ready
    );
    modport sink (
        input  valid, year, month, day, hour, minute, second, offset_seconds,
        output ready
    );
endinterface

// ===== design/rtcdt_result_if.sv =====
// ----------------------------------------------------------------------------
// rtcdt_result_if
// Output channel: valid flag and packed BCD fields with valid/ready.
// ----------------------------------------------------------------------------
interface rtcdt_result_if;
    logic       valid;
    logic       ready;
    logic       valid_res;
    logic [7:0] bcd_year;
    logic [7:0] bcd_month;
    logic [7:0] bcd_day;
    logic [7:0] bcd_hour;
    logic [7:0] bcd_minute;
    logic [7:0] bcd_second;

    modport source (
        output valid, valid_res, bcd_year, bcd_month, bcd_day, bcd_hour,
               bcd_minute, bcd_second,
        input  ready
    );
    modport sink (
        input  valid, valid_res, bcd_year, bcd_month, bcd_day, bcd_hour,
               bcd_minute, bcd_second,
        output ready
    );
endinterface

// ===== design/rtcdt_front.sv =====
// ----------------------------------------------------------------------------
// rtcdt_front
// Accepts items, checks the calendar rules and clamps the offset.
// ----------------------------------------------------------------------------
module rtcdt_front
    import rtcdt_pkg::*;
(
    rtcdt_item_if.sink   item,
    input  logic         full,
    output logic         push,
    output rtcdt_entry_t entry
);

    logic       leap;
    logic [4:0] mlen;
    logic [11:0] yoff;

    // in range 2013..2099 a year is leap exactly when divisible by four
    assign leap = (item.year[1:0] == 2'b00);
    assign mlen = month_len(item.month, leap);
    assign yoff = item.year - YEAR_BASE;

    assign item.ready = !full;
    assign push       = item.valid && !full;

    always_comb
    begin
        entry.ok = (item.year >= YEAR_MIN) && (item.year <= YEAR_MAX) &&
                   (item.month != 4'd0) && (item.month <= MONTH_LAST) &&
                   (item.hour <= HOUR_LAST) && (item.minute <= MIN_LAST) &&
                   (item.second <= SEC_LAST) &&
                   (item.day != 5'd0) && (item.day <= mlen);
        entry.yy     = yoff[6:0];
        entry.month  = item.month;
        entry.day    = item.day;
        entry.hour   = item.hour;
        entry.minute = item.minute;
        entry.second = item.second;
        entry.offs   = (item.offset_seconds > OFFSET_MAX) ? OFFSET_MAX : item.offset_seconds;
        entry.mlen   = mlen;
    end

endmodule

// ===== design/rtcdt_queue.sv =====
// ----------------------------------------------------------------------------
// rtcdt_queue
// Small FIFO of checked entries between the front and back parts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtcdt_queue
    import rtcdt_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  rtcdt_entry_t wr_entry,
    input  logic         pop,
    output logic         full,
    output logic         empty,
    output rtcdt_entry_t rd_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rtcdt_entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign rd_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    `ASSERT_IMPL(a_no_push_full, clk, rst_n, push, !full)
    `ASSERT_IMPL(a_no_pop_empty, clk, rst_n, pop, !empty)
    `ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

// ===== design/rtcdt_back.sv =====
// ----------------------------------------------------------------------------
// rtcdt_back
// Adds the offset, ripples the carry and registers the BCD result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtcdt_back
    import rtcdt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  rtcdt_entry_t  head,
    input  logic          head_valid,
    output logic          pop,
    rtcdt_result_if.source result
);

    logic       out_valid_reg, out_valid_next;
    logic       valid_res_reg;
    logic [7:0] bcd_year_reg, bcd_month_reg, bcd_day_reg;
    logic [7:0] bcd_hour_reg, bcd_minute_reg, bcd_second_reg;

    logic [6:0] sec_sum;
    logic       c_sec, c_min, c_hour, c_day, c_mon;
    logic [5:0] sec_n, min_n;
    logic [4:0] hour_n, day_n;
    logic [3:0] mon_n;
    logic [6:0] yy_n;
    logic       bcd_zero;

    assign pop = head_valid && (!out_valid_reg || result.ready);

    always_comb
    begin
        sec_sum = {1'b0, head.second} + {1'b0, head.offs};
        c_sec   = (sec_sum >= SEC_WRAP);
        sec_n   = c_sec ? 6'(sec_sum - SEC_WRAP) : sec_sum[5:0];
        c_min   = c_sec && (head.minute == MIN_LAST);
        min_n   = c_min ? 6'd0 : head.minute + {5'd0, c_sec};
        c_hour  = c_min && (head.hour == HOUR_LAST);
        hour_n  = c_hour ? 5'd0 : head.hour + {4'd0, c_min};
        c_day   = c_hour && (head.day == head.mlen);
        day_n   = c_day ? 5'd1 : head.day + {4'd0, c_hour};
        c_mon   = c_day && (head.month == MONTH_LAST);
        mon_n   = c_mon ? 4'd1 : head.month + {3'd0, c_day};
        if (c_mon)
        begin
            yy_n = (head.yy == YY_LAST) ? 7'd0 : head.yy + 7'd1;
        end
        else
        begin
            yy_n = head.yy;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            valid_res_reg  <= head.ok;
            bcd_year_reg   <= head.ok ? to_bcd(yy_n) : 8'd0;
            bcd_month_reg  <= head.ok ? to_bcd({3'd0, mon_n}) : 8'd0;
            bcd_day_reg    <= head.ok ? to_bcd({2'd0, day_n}) : 8'd0;
            bcd_hour_reg   <= head.ok ? to_bcd({2'd0, hour_n}) : 8'd0;
            bcd_minute_reg <= head.ok ? to_bcd({1'b0, min_n}) : 8'd0;
            bcd_second_reg <= head.ok ? to_bcd({1'b0, sec_n}) : 8'd0;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.valid_res  = valid_res_reg;
    assign result.bcd_year   = bcd_year_reg;
    assign result.bcd_month  = bcd_month_reg;
    assign result.bcd_day    = bcd_day_reg;
    assign result.bcd_hour   = bcd_hour_reg;
    assign result.bcd_minute = bcd_minute_reg;
    assign result.bcd_second = bcd_second_reg;

    assign bcd_zero = (bcd_year_reg == 8'd0) && (bcd_month_reg == 8'd0) &&
                      (bcd_day_reg == 8'd0) && (bcd_hour_reg == 8'd0) &&
                      (bcd_minute_reg == 8'd0) && (bcd_second_reg == 8'd0);

    `ASSERT_NEXT(a_load_shows, clk, rst_n, pop, out_valid_reg)
    `ASSERT_IMPL(a_invalid_zero, clk, rst_n, out_valid_reg && !valid_res_reg, bcd_zero)
    `ASSERT_NEXT(a_hold_stall, clk, rst_n, out_valid_reg && !result.ready, out_valid_reg)

endmodule

// ===== design/rtc_date_time_check_and_bcd.sv =====
// ----------------------------------------------------------------------------
// rtc_date_time_check_and_bcd
// Checks a calendar date and time, adds a seconds offset and packs BCD.
// ----------------------------------------------------------------------------
// Each result passes through a queue slot, then the output register.
// Throughput: one transaction per cycle while the result side is ready; the
// check feeds the queue directly and the carry/BCD stage loads its output
// register from the queue head.
// The queue absorbs DEPTH transactions while the result side stalls.
// Reset clears queue pointers, count and result valid; data is not cleared.
module rtc_date_time_check_and_bcd
    import rtcdt_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    rtcdt_item_if.sink     item,
    rtcdt_result_if.source result
);

    rtcdt_entry_t wr_entry;
    rtcdt_entry_t rd_entry;
    logic         push;
    logic         pop;
    logic         full;
    logic         empty;

    rtcdt_front u_front (
        .item  (item),
        .full  (full),
        .push  (push),
        .entry (wr_entry)
    );

    rtcdt_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .rd_entry (rd_entry)
    );

    rtcdt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (rd_entry),
        .head_valid (!empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

// ===== verif/rtcdt_bcd_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcdt_bcd_check
// Watches both channels of the RTC date/time block and checks its results.
// Every input transaction is run through a calendar model: range and
// month-length checks, seconds offset with a single carry chain, and
// two-digit BCD packing. Each output transaction is compared field by field
// with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module rtcdt_bcd_check
    import rtcdt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    rtcdt_item_if   item_mon,
    rtcdt_result_if result_mon,
    output int      fail_count,
    output int      pending_count,
    output int      result_count,
    output int      valid_count
);

    typedef struct packed {
        logic       ok;
        logic [7:0] yy;
        logic [7:0] mm;
        logic [7:0] dd;
        logic [7:0] hh;
        logic [7:0] mi;
        logic [7:0] ss;
    } rtc_stamp_t;

    rtc_stamp_t expected_stamps[$];
    int         mismatches = 0;
    int         pending    = 0;
    int         taken      = 0;
    int         taken_ok   = 0;

    assign fail_count    = mismatches;
    assign pending_count = pending;
    assign result_count  = taken;
    assign valid_count   = taken_ok;

    function automatic int days_in_month(input int mo, input int yr);
        bit leap;
        leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
        case (mo)
            4, 6, 9, 11: return 30;
            2:           return leap ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    function automatic logic [7:0] bcd_pair(input int v);
        int r;
        r = v % 100;
        return 8'(((r / 10) << 4) | (r % 10));
    endfunction

    function automatic rtc_stamp_t advance_and_pack(
        input logic [11:0] yr_in,
        input logic [3:0]  mo_in,
        input logic [4:0]  dd_in,
        input logic [4:0]  hh_in,
        input logic [5:0]  mi_in,
        input logic [5:0]  ss_in,
        input logic [5:0]  off_in
    );
        int         yr, mo, dd, hh, mi, ss, off;
        rtc_stamp_t stamp;
        yr    = yr_in;
        mo    = mo_in;
        dd    = dd_in;
        hh    = hh_in;
        mi    = mi_in;
        ss    = ss_in;
        off   = (off_in > OFFSET_MAX) ? int'(OFFSET_MAX) : int'(off_in);
        stamp = '0;
        if (yr < YEAR_MIN || yr > YEAR_MAX || mo < 1 || mo > 12 || dd < 1 ||
            hh > 23 || mi > 59 || ss > 59)
            return stamp;
        if (dd > days_in_month(mo, yr))
            return stamp;
        ss = ss + off;
        if (ss >= 60)
        begin
            ss = ss - 60;
            mi++;
            if (mi == 60)
            begin
                mi = 0;
                hh++;
                if (hh == 24)
                begin
                    hh = 0;
                    dd++;
                    if (dd > days_in_month(mo, yr))
                    begin
                        dd = 1;
                        mo++;
                        if (mo == 13)
                        begin
                            mo = 1;
                            yr++;
                        end
                    end
                end
            end
        end
        stamp.ok = 1'b1;
        stamp.yy = bcd_pair(yr - YEAR_BASE);
        stamp.mm = bcd_pair(mo);
        stamp.dd = bcd_pair(dd);
        stamp.hh = bcd_pair(hh);
        stamp.mi = bcd_pair(mi);
        stamp.ss = bcd_pair(ss);
        return stamp;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH transaction %0d %s: got %02h expected %02h",
                 taken, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge clk)
    begin : watch_channels
        rtc_stamp_t want;
        if (rst_n)
        begin
            if (result_mon.valid && result_mon.ready)
            begin
                taken++;
                if (result_mon.valid_res)
                    taken_ok++;
                if (expected_stamps.size() == 0)
                begin
                    report_mismatch("arrived with none pending", result_mon.valid_res, 0);
                end
                else
                begin
                    want = expected_stamps.pop_front();
                    check_field("valid_res", result_mon.valid_res, want.ok);
                    check_field("bcd_year", result_mon.bcd_year, want.yy);
                    check_field("bcd_month", result_mon.bcd_month, want.mm);
                    check_field("bcd_day", result_mon.bcd_day, want.dd);
                    check_field("bcd_hour", result_mon.bcd_hour, want.hh);
                    check_field("bcd_minute", result_mon.bcd_minute, want.mi);
                    check_field("bcd_second", result_mon.bcd_second, want.ss);
                end
            end
            if (item_mon.valid && item_mon.ready)
                expected_stamps.push_back(advance_and_pack(
                    item_mon.year, item_mon.month, item_mon.day, item_mon.hour,
                    item_mon.minute, item_mon.second, item_mon.offset_seconds));
            pending = expected_stamps.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Top level for the RTC date/time check and BCD block.
// Drives a directed set of calendar corner cases, then random dates that are
// mostly well formed with some raw noise, under random gaps on the input and
// random stalls on the output, including long output hold-offs that back the
// block up. Checking is done by rtcdt_bcd_check; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RANDOM_ITEMS = 1300;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 400000;

    logic clk;
    logic rst_n;
    int   cycles    = 0;
    int   sent      = 0;
    int   directed  = 0;
    int   holds     = 0;
    int   fail_count;
    int   pending_count;
    int   result_count;
    int   valid_count;

    rtcdt_item_if   item_ch ();
    rtcdt_result_if result_ch ();

    rtc_date_time_check_and_bcd u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    rtcdt_bcd_check u_bcd_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_mon      (item_ch),
        .result_mon    (result_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .result_count  (result_count),
        .valid_count   (valid_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results pending", cycles, pending_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int pick_wait(input int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 18);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
        endcase
    endfunction

    task automatic send_stamp(
        input int          mode,
        input logic [11:0] yr,
        input logic [3:0]  mo,
        input logic [4:0]  dd,
        input logic [4:0]  hh,
        input logic [5:0]  mi,
        input logic [5:0]  ss,
        input logic [5:0]  off
    );
        int gap;
        gap = pick_wait(mode);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.year           <= yr;
        item_ch.month          <= mo;
        item_ch.day            <= dd;
        item_ch.hour           <= hh;
        item_ch.minute         <= mi;
        item_ch.second         <= ss;
        item_ch.offset_seconds <= off;
        do @(posedge clk); while (!item_ch.ready);
        sent++;
    endtask

    task automatic drain_results();
        int taken;
        int stall;
        int mode;
        taken = 0;
        mode  = 1;
        forever
        begin
            stall = pick_wait(mode);
            if (taken == 150 || taken == 700)
            begin
                stall = LONG_HOLD;
                holds++;
            end
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            taken++;
            if (taken % 64 == 0)
                mode = $urandom_range(0, 2);
        end
    endtask

    initial
    begin : stimulus
        int          mode;
        logic [11:0] yr;
        logic [3:0]  mo;
        logic [4:0]  dd;
        logic [4:0]  hh;
        logic [5:0]  mi;
        logic [5:0]  ss;
        logic [5:0]  off;

        rst_n                  <= 1'b0;
        item_ch.valid          <= 1'b0;
        item_ch.year           <= '0;
        item_ch.month          <= '0;
        item_ch.day            <= '0;
        item_ch.hour           <= '0;
        item_ch.minute         <= '0;
        item_ch.second         <= '0;
        item_ch.offset_seconds <= '0;
        result_ch.ready        <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        fork
            drain_results();
        join_none

        mode = 1;
        send_stamp(mode, 12'd2013, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 6'd0);
        send_stamp(mode, 12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 6'd1);
        send_stamp(mode, 12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd30, 6'd63);
        send_stamp(mode, 12'd2012, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 6'd1);
        send_stamp(mode, 12'd2100, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 6'd0);
        send_stamp(mode, 12'hFFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F, 6'h3F);
        send_stamp(mode, 12'h000, 4'h0, 5'h00, 5'h00, 6'h00, 6'h00, 6'h00);
        send_stamp(mode, 12'd2016, 4'd2, 5'd29, 5'd23, 6'd59, 6'd59, 6'd1);
        send_stamp(mode, 12'd2015, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0, 6'd5);
        send_stamp(mode, 12'd2015, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59, 6'd60);
        send_stamp(mode, 12'd2020, 4'd4, 5'd30, 5'd23, 6'd59, 6'd0, 6'd60);
        send_stamp(mode, 12'd2020, 4'd4, 5'd31, 5'd10, 6'd10, 6'd10, 6'd1);
        send_stamp(mode, 12'd2020, 4'd6, 5'd30, 5'd12, 6'd0, 6'd0, 6'd0);
        send_stamp(mode, 12'd2020, 4'd0, 5'd10, 5'd12, 6'd0, 6'd0, 6'd1);
        send_stamp(mode, 12'd2020, 4'd13, 5'd10, 5'd12, 6'd0, 6'd0, 6'd1);
        send_stamp(mode, 12'd2020, 4'd5, 5'd0, 5'd12, 6'd0, 6'd0, 6'd1);
        send_stamp(mode, 12'd2020, 4'd5, 5'd10, 5'd24, 6'd0, 6'd0, 6'd1);
        send_stamp(mode, 12'd2020, 4'd5, 5'd10, 5'd12, 6'd60, 6'd0, 6'd1);
        send_stamp(mode, 12'd2020, 4'd5, 5'd10, 5'd12, 6'd0, 6'd60, 6'd1);
        send_stamp(mode, 12'd2050, 4'd7, 5'd31, 5'd23, 6'd59, 6'd59, 6'd61);
        send_stamp(mode, 12'd2050, 4'd11, 5'd30, 5'd10, 6'd59, 6'd59, 6'd1);
        send_stamp(mode, 12'd2024, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 6'd1);
        send_stamp(mode, 12'd2030, 4'd9, 5'd15, 5'd8, 6'd30, 6'd20, 6'd39);
        send_stamp(mode, 12'd2030, 4'd1, 5'd31, 5'd23, 6'd59, 6'd59, 6'd1);
        directed = sent;

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
                mode = $urandom_range(0, 2);
            if ($urandom_range(0, 4) == 0)
            begin
                yr  = 12'($urandom);
                mo  = 4'($urandom);
                dd  = 5'($urandom);
                hh  = 5'($urandom);
                mi  = 6'($urandom);
                ss  = 6'($urandom);
                off = 6'($urandom);
            end
            else
            begin
                yr = ($urandom_range(0, 7) == 0) ? 12'd2099 : 12'($urandom_range(2013, 2099));
                mo = ($urandom_range(0, 3) == 0) ? 4'd12 : 4'($urandom_range(1, 12));
                case ($urandom_range(0, 2))
                    0:       dd = 5'($urandom_range(1, 28));
                    1:       dd = 5'($urandom_range(28, 31));
                    default: dd = ($urandom_range(0, 1) == 0) ? 5'd1 : 5'($urandom_range(29, 31));
                endcase
                hh  = ($urandom_range(0, 2) == 0) ? 5'd23 : 5'($urandom_range(0, 23));
                mi  = ($urandom_range(0, 2) == 0) ? 6'd59 : 6'($urandom_range(0, 59));
                ss  = ($urandom_range(0, 2) == 0) ? 6'd59 : 6'($urandom_range(0, 59));
                off = 6'($urandom_range(0, 63));
            end
            send_stamp(mode, yr, mo, dd, hh, mi, ss, off);
        end
        item_ch.valid <= 1'b0;

        while (result_count < sent || pending_count != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d date/time transactions (%0d directed), checked %0d results, %0d valid",
                 sent, directed, result_count, valid_count);
        $display("Output side held off %0d times for %0d cycles with input still offered",
                 holds, LONG_HOLD);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/rtcdt_pkg.sv
design/rtcdt_item_if.sv
design/rtcdt_result_if.sv
design/rtcdt_front.sv
design/rtcdt_queue.sv
design/rtcdt_back.sv
design/rtc_date_time_check_and_bcd.sv
verif/rtcdt_bcd_check.sv
verif/testbench.sv
